// ----- hdl/sfr_pkg.sv -----
// Shared types and constants for the serial frame receiver.
// Used by the channel interfaces and every module of the receiver.
`default_nettype none

package sfr_pkg;

   localparam int COUNT_W = 13;
   localparam int TICK_W  = 16;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [COUNT_W-1:0] MAX_FRAME_BYTES = 13'd8191;

   // Request actions.
   localparam logic [1:0] ACT_BYTE    = 2'd0;
   localparam logic [1:0] ACT_TICK    = 2'd1;
   localparam logic [1:0] ACT_RESTART = 2'd2;

   // Reply phases, reported as status.
   localparam logic [1:0] PH_BUSY     = 2'd0;
   localparam logic [1:0] PH_DONE     = 2'd1;
   localparam logic [1:0] PH_TIMEOUT  = 2'd2;
   localparam logic [1:0] PH_OVERFLOW = 2'd3;

   // Frame modes.
   localparam logic [1:0] MODE_BINARY  = 2'd0;
   localparam logic [1:0] MODE_BASIC   = 2'd1;
   localparam logic [1:0] MODE_GENERIC = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_OPEN     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_LIMIT = 2'd2;

   localparam logic [7:0] CHAR_LT     = 8'h3C;
   localparam logic [7:0] CHAR_GT     = 8'h3E;
   localparam logic [7:0] HEADER_BYTE = 8'hC3;
   localparam logic [COUNT_W-1:0] BIN_OVERHEAD = 13'd11;

   typedef struct packed {
      logic [1:0]        frame_mode;
      logic              port_open;
      logic [TICK_W-1:0] timeout_limit;
   } cfg_type;

   typedef struct packed {
      logic [7:0]         out_byte;
      logic               byte_kept;
      logic [COUNT_W-1:0] byte_index;
      logic [1:0]         status;
      logic [COUNT_W-1:0] frame_length;
   } result_type;

endpackage

`default_nettype wire

// ----- hdl/sfr_channels.sv -----
// Valid/ready channel interfaces for the serial frame receiver.
// Depends on sfr_pkg for field widths.
`default_nettype none

interface sfr_req_if import sfr_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] rx_byte;

   modport source (output valid, output action, output rx_byte, input ready);
   modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface sfr_rsp_if import sfr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [7:0]         out_byte;
   logic               byte_kept;
   logic [COUNT_W-1:0] byte_index;
   logic [1:0]         status;
   logic [COUNT_W-1:0] frame_length;

   modport source (output valid, output out_byte, output byte_kept, output byte_index,
                   output status, output frame_length, input ready);
   modport sink (input valid, input out_byte, input byte_kept, input byte_index,
                 input status, input frame_length, output ready);
endinterface

`default_nettype wire

// ----- hdl/sfr_csr_regs.sv -----
// Configuration registers of the serial frame receiver.
// Depends on sfr_pkg for the register indexes and the config struct.
`default_nettype none

module sfr_csr_regs import sfr_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_FRAME_MODE:    cfg_in.frame_mode    = csr_wdata[1:0];
            CSR_PORT_OPEN:     cfg_in.port_open     = csr_wdata[0];
            CSR_TIMEOUT_LIMIT: cfg_in.timeout_limit = csr_wdata[TICK_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_mode    <= MODE_BASIC;
         cfg_ff.port_open     <= 1'b0;
         cfg_ff.timeout_limit <= 16'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- hdl/sfr_frame_engine.sv -----
// Frame tracking state and the per-request decision logic.
// Depends on sfr_pkg; updates its state on each accepted request.
`default_nettype none

module sfr_frame_engine import sfr_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [1:0] action,
   input  wire logic [7:0] rx_byte,
   input  wire cfg_type    cfg,
   output result_type      result
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         first_ff, first_in;
   logic [7:0]         len_low_ff, len_low_in;
   logic [3:0]         len_high_ff, len_high_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [1:0]         phase_ff, phase_in;

   logic [COUNT_W-1:0] count_next;
   logic [COUNT_W:0]   bin_target;
   logic               wants;
   result_type         res;

   assign count_next = count_ff + 1'b1;
   assign bin_target = {1'b0, len_high_ff, len_low_ff} + {1'b0, BIN_OVERHEAD};
   assign wants = !(cfg.frame_mode == MODE_GENERIC && count_ff == '0 && rx_byte != CHAR_LT);

   always_comb begin
      count_in    = count_ff;
      first_in    = first_ff;
      len_low_in  = len_low_ff;
      len_high_in = len_high_ff;
      tick_in     = tick_ff;
      phase_in    = phase_ff;
      res.out_byte     = 8'd0;
      res.byte_kept    = 1'b0;
      res.byte_index   = '0;
      res.status       = phase_ff;
      res.frame_length = count_ff;

      if (!cfg.port_open) begin
         res.status       = PH_TIMEOUT;
         res.frame_length = '0;
      end else begin
         case (action)
            ACT_RESTART: begin
               count_in    = '0;
               first_in    = 8'd0;
               len_low_in  = 8'd0;
               len_high_in = 4'd0;
               tick_in     = '0;
               phase_in    = PH_BUSY;
               res.status       = PH_BUSY;
               res.frame_length = '0;
            end
            ACT_TICK: begin
               if (phase_ff == PH_BUSY) begin
                  if (tick_ff >= cfg.timeout_limit) begin
                     phase_in = PH_TIMEOUT;
                  end else begin
                     tick_in = tick_ff + 1'b1;
                  end
               end
               res.status = phase_in;
            end
            ACT_BYTE: begin
               res.out_byte = rx_byte;
               if (phase_ff == PH_BUSY && wants) begin
                  if (count_ff >= MAX_FRAME_BYTES) begin
                     phase_in = PH_OVERFLOW;
                  end else begin
                     res.byte_index = count_ff;
                     res.byte_kept  = 1'b1;
                     count_in       = count_next;
                     case (cfg.frame_mode)
                        MODE_BINARY: begin
                           if (count_ff == 13'd0) first_in = rx_byte;
                           if (count_ff == 13'd7) len_low_in = rx_byte;
                           if (count_ff == 13'd8) len_high_in = rx_byte[3:0];
                           // A bad header drops the second byte and starts over.
                           if (count_next == 13'd2 &&
                               !(first_ff == CHAR_LT && rx_byte == HEADER_BYTE)) begin
                              count_in       = '0;
                              res.byte_kept  = 1'b0;
                              res.byte_index = '0;
                           end else if (count_next >= BIN_OVERHEAD && rx_byte == CHAR_GT &&
                                        {1'b0, count_next} == bin_target) begin
                              phase_in = PH_DONE;
                           end
                        end
                        MODE_GENERIC: begin
                           if (count_ff != '0 && rx_byte == CHAR_GT) phase_in = PH_DONE;
                        end
                        default: begin
                           if (count_next >= 13'd2) phase_in = PH_DONE;
                        end
                     endcase
                  end
               end
               res.status       = phase_in;
               res.frame_length = count_in;
            end
            default: begin
               res.status = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         first_ff    <= 8'd0;
         len_low_ff  <= 8'd0;
         len_high_ff <= 4'd0;
         tick_ff     <= '0;
         phase_ff    <= PH_BUSY;
      end else if (accept) begin
         count_ff    <= count_in;
         first_ff    <= first_in;
         len_low_ff  <= len_low_in;
         len_high_ff <= len_high_in;
         tick_ff     <= tick_in;
         phase_ff    <= phase_in;
      end
   end

   assign result = res;

endmodule

`default_nettype wire

// ----- hdl/sfr_out_reg.sv -----
// Result register driving the response channel.
// Depends on sfr_pkg and the sfr_rsp_if interface.
`default_nettype none

module sfr_out_reg import sfr_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire result_type result,
   output logic            can_load,
   sfr_rsp_if.source       rsp_chan
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   // The register takes a new result whenever it is empty or being drained.
   assign can_load = !valid_ff || rsp_chan.ready;
   assign valid_in = load ? 1'b1 : (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.out_byte     = data_ff.out_byte;
   assign rsp_chan.byte_kept    = data_ff.byte_kept;
   assign rsp_chan.byte_index   = data_ff.byte_index;
   assign rsp_chan.status       = data_ff.status;
   assign rsp_chan.frame_length = data_ff.frame_length;

endmodule

`default_nettype wire

// ----- hdl/serial_frame_receiver_unit.sv -----
// Top level of the serial frame receiver: config registers, frame engine
// and result register. Depends on sfr_pkg, sfr_channels and the sfr_ modules.
//
//   Channel   Direction  Handshake          Contents
//   req_chan  in         valid/ready        action, rx_byte
//   rsp_chan  out        valid/ready        out_byte, byte_kept, byte_index,
//                                           status, frame_length
//   csr_*     in         write enable only  index, write data
//
// The frame state updates and the result is registered at the edge that accepts
// the request, so requests can arrive every cycle while the result register can
// take them. Reset is synchronous and restores the default configuration
// and an empty, busy frame. A request is accepted while the result register is
// empty or is being emptied in the same cycle, so a stall on the response side
// holds the request side only once a result is already waiting.
`default_nettype none

module serial_frame_receiver_unit import sfr_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   sfr_req_if.sink                   req_chan,
   sfr_rsp_if.source                 rsp_chan,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   cfg_type    cfg;
   result_type result;
   logic       can_load;
   logic       accept;

   assign req_chan.ready = can_load;
   assign accept = req_chan.valid && can_load;

   sfr_csr_regs u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   sfr_frame_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .action  (req_chan.action),
      .rx_byte (req_chan.rx_byte),
      .cfg     (cfg),
      .result  (result)
   );

   sfr_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .result   (result),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking bench for serial_frame_receiver_unit: directed table, then random
// frames in every mode.
// Depends on sfr_pkg, sfr_channels and the receiver RTL.
module tb_top import sfr_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_ITEMS = 500;

   typedef struct packed {
      logic              is_cfg;
      logic [1:0]        code;
      logic [CSR_W-1:0]  value;
      logic              pinned;
      result_type        want;
   } plan_row_type;

   typedef struct packed {
      logic       pinned;
      result_type value;
   } fixed_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   sfr_req_if req_if ();
   sfr_rsp_if rsp_if ();

   serial_frame_receiver_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Mirror of the configuration and of the frame state.
   logic [1:0]         cfg_mode;
   logic               cfg_port_open;
   logic [TICK_W-1:0]  cfg_timeout;
   logic [COUNT_W-1:0] rx_count;
   logic [7:0]         hdr_first;
   logic [7:0]         len_low;
   logic [3:0]         len_high;
   logic [TICK_W-1:0]  tick_total;
   logic [1:0]         reply_phase;

   result_type      reply_q[$];
   fixed_reply_type fixed_reply_q[$];
   plan_row_type    plan[$];

   result_type      req_reply;
   result_type      rsp_seen;
   fixed_reply_type fixed;
   int failures = 0;
   int quiet_cycles = 0;
   int random_sent = 0;
   int ready_hold = 0;
   int stall;
   bit no_gaps = 1'b0;

   always #5 clock = ~clock;

   function automatic void clear_frame();
      rx_count = '0;
      hdr_first = '0;
      len_low = '0;
      len_high = '0;
      tick_total = '0;
      reply_phase = PH_BUSY;
   endfunction

   function automatic result_type predict_response(input logic [1:0] act,
                                                    input logic [7:0] data);
      result_type r;
      bit wants;
      r = '0;
      if (!cfg_port_open) begin
         r.status = PH_TIMEOUT;
         return r;
      end
      if (act == ACT_RESTART) begin
         clear_frame();
         return r;
      end
      if (act == ACT_UNUSED || reply_phase != PH_BUSY) begin
         if (act == ACT_BYTE) r.out_byte = data;
         r.status = reply_phase;
         r.frame_length = rx_count;
         return r;
      end
      if (act == ACT_TICK) begin
         if (tick_total >= cfg_timeout) reply_phase = PH_TIMEOUT;
         else tick_total = tick_total + 1'b1;
         r.status = reply_phase;
         r.frame_length = rx_count;
         return r;
      end
      // A generic frame only opens on '<'; anything before it is dropped.
      wants = !(cfg_mode == MODE_GENERIC && rx_count == 0 && data != CHAR_LT);
      r.out_byte = data;
      if (wants && rx_count >= MAX_FRAME_BYTES) begin
         reply_phase = PH_OVERFLOW;
      end else if (wants) begin
         r.byte_kept = 1'b1;
         r.byte_index = rx_count;
         rx_count = rx_count + 1'b1;
         case (cfg_mode)
            MODE_BINARY: begin
               if (r.byte_index == 0) hdr_first = data;
               if (r.byte_index == 7) len_low = data;
               if (r.byte_index == 8) len_high = data[3:0];
               if (rx_count == 2 && !(hdr_first == CHAR_LT && data == HEADER_BYTE)) begin
                  rx_count = '0;
                  r.byte_kept = 1'b0;
                  r.byte_index = '0;
               end
               // The length low byte counts as unsigned, so 0x80..0xFF add 128..255.
               if (rx_count >= BIN_OVERHEAD && data == CHAR_GT &&
                   int'(rx_count) == int'(len_low) + 256 * int'(len_high) +
                   int'(BIN_OVERHEAD))
                  reply_phase = PH_DONE;
            end
            MODE_GENERIC: begin
               if (r.byte_index != 0 && data == CHAR_GT) reply_phase = PH_DONE;
            end
            default: begin
               if (rx_count >= 2) reply_phase = PH_DONE;
            end
         endcase
      end
      r.status = reply_phase;
      r.frame_length = rx_count;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] rand_byte_not(input logic [7:0] avoid);
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == avoid);
      return b;
   endfunction

   function automatic void add_cfg(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_W-1:0] value);
      plan_row_type row;
      row = '0;
      row.is_cfg = 1'b1;
      row.code = idx;
      row.value = value;
      plan.push_back(row);
   endfunction

   function automatic void add_req(input logic [1:0] act, input logic [7:0] data);
      plan_row_type row;
      row = '0;
      row.code = act;
      row.value = {8'h00, data};
      plan.push_back(row);
   endfunction

   function automatic void add_reply(input logic [1:0] act, input logic [7:0] data,
                                     input logic [7:0] ob, input logic kept,
                                     input logic [COUNT_W-1:0] idx, input logic [1:0] st,
                                     input logic [COUNT_W-1:0] len);
      plan_row_type row;
      row = '0;
      row.code = act;
      row.value = {8'h00, data};
      row.pinned = 1'b1;
      row.want.out_byte = ob;
      row.want.byte_kept = kept;
      row.want.byte_index = idx;
      row.want.status = st;
      row.want.frame_length = len;
      plan.push_back(row);
   endfunction

   task automatic check_reply(input result_type got);
      result_type want;
      if (reply_q.size() == 0) begin
         $error("response with no request pending: status %0d", got.status);
         failures++;
         return;
      end
      want = reply_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
         $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
         failures++;
      end
      if (got.byte_kept !== want.byte_kept) begin
         $error("byte_kept: expected %0d, got %0d", want.byte_kept, got.byte_kept);
         failures++;
      end
      if (got.byte_index !== want.byte_index) begin
         $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
         failures++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         failures++;
      end
      if (got.frame_length !== want.frame_length) begin
         $error("frame_length: expected %0d, got %0d", want.frame_length,
                got.frame_length);
         failures++;
      end
   endtask

   // Requests and responses are both sampled here, at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
            req_reply = predict_response(req_if.action, req_if.rx_byte);
            fixed = fixed_reply_q.pop_front();
            reply_q.push_back(fixed.pinned ? fixed.value : req_reply);
         end
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            rsp_seen.out_byte = rsp_if.out_byte;
            rsp_seen.byte_kept = rsp_if.byte_kept;
            rsp_seen.byte_index = rsp_if.byte_index;
            rsp_seen.status = rsp_if.status;
            rsp_seen.frame_length = rsp_if.frame_length;
            check_reply(rsp_seen);
         end
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Response side back-pressure: runs of ready, then stalls of random length.
   always @(negedge clock) begin
      if (ready_hold > 0) begin
         ready_hold--;
      end else if (no_gaps) begin
         rsp_if.ready <= 1'b1;
      end else begin
         stall = pick_gap();
         rsp_if.ready <= (stall == 0);
         ready_hold = (stall == 0) ? $urandom_range(0, 4) : stall - 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance with
   // valid still high, so a back-to-back request keeps it high.
   task automatic send_request(input logic [1:0] act, input logic [7:0] data,
                               input logic pinned, input result_type want);
      int gap;
      fixed_reply_type entry;
      gap = pick_gap();
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      entry.pinned = pinned;
      entry.value = want;
      fixed_reply_q.push_back(entry);
      req_if.valid <= 1'b1;
      req_if.action <= act;
      req_if.rx_byte <= data;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic send(input logic [1:0] act, input logic [7:0] data);
      send_request(act, data, 1'b0, '0);
      random_sent++;
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (reply_q.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_FRAME_MODE:    cfg_mode = data[1:0];
         CSR_PORT_OPEN:     cfg_port_open = data[0];
         CSR_TIMEOUT_LIMIT: cfg_timeout = data;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // Stray ticks and random requests between the bytes of a frame.
   task automatic frame_byte(input logic [7:0] data);
      int r;
      logic [1:0] act;
      r = $urandom_range(0, 99);
      act = 2'($urandom_range(0, 3));
      if (r < 8) send(ACT_TICK, 8'($urandom_range(0, 255)));
      else if (r < 11) send(act, 8'($urandom_range(0, 255)));
      send(ACT_BYTE, data);
   endtask

   task automatic binary_frame();
      int r;
      int len;
      logic [7:0] lo;
      logic [7:0] hi;
      r = $urandom_range(0, 99);
      lo = 8'($urandom_range(0, 10));
      hi = 8'($urandom_range(0, 255));
      hi[3:0] = 4'h0;
      if (r >= 97) hi[3:0] = 4'h1;
      else if (r >= 85) lo = 8'($urandom_range(128, 255));
      len = int'(lo) + 256 * int'(hi[3:0]);
      r = $urandom_range(0, 99);
      frame_byte(r < 7 ? rand_byte_not(CHAR_LT) : CHAR_LT);
      frame_byte((r >= 7 && r < 14) ? rand_byte_not(HEADER_BYTE) : HEADER_BYTE);
      repeat (5) frame_byte(8'($urandom_range(0, 255)));
      frame_byte(lo);
      frame_byte(hi);
      repeat (len + 1) frame_byte(8'($urandom_range(0, 255)));
      frame_byte($urandom_range(0, 99) < 90 ? CHAR_GT : rand_byte_not(CHAR_GT));
   endtask

   task automatic generic_frame();
      repeat ($urandom_range(0, 3)) frame_byte(rand_byte_not(CHAR_LT));
      frame_byte(CHAR_LT);
      repeat ($urandom_range(0, 8)) frame_byte(rand_byte_not(CHAR_GT));
      frame_byte(CHAR_GT);
   endtask

   task automatic run_frame();
      if (cfg_timeout <= 20 && $urandom_range(0, 99) < 30)
         repeat ($urandom_range(0, int'(cfg_timeout) + 2))
            send(ACT_TICK, 8'($urandom_range(0, 255)));
      case (cfg_mode)
         MODE_BINARY:  binary_frame();
         MODE_GENERIC: generic_frame();
         default:      repeat (2) frame_byte(8'($urandom_range(0, 255)));
      endcase
      // Up to two requests after the frame's bytes, then a restart.
      repeat ($urandom_range(0, 2))
         send(($urandom_range(0, 1) != 0) ? ACT_TICK : ACT_BYTE,
              8'($urandom_range(0, 255)));
      send(ACT_RESTART, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      int phase_no;
      int phase_end;
      int r;
      logic [1:0] mode;
      logic [TICK_W-1:0] limit;
      logic open;
      logic [13:0] filler;

      req_if.valid = 1'b0;
      req_if.action = ACT_BYTE;
      req_if.rx_byte = 8'h00;
      rsp_if.ready = 1'b0;
      csr_write_en = 1'b0;
      csr_index = CSR_FRAME_MODE;
      csr_wdata = '0;
      cfg_mode = MODE_BASIC;
      cfg_port_open = 1'b0;
      cfg_timeout = 16'd1000;
      clear_frame();

      // Port closed after reset, then basic mode at its reset value.
      add_reply(ACT_BYTE, 8'hFF, 8'h00, 1'b0, 13'd0, PH_TIMEOUT, 13'd0);
      add_reply(ACT_TICK, 8'h00, 8'h00, 1'b0, 13'd0, PH_TIMEOUT, 13'd0);
      add_cfg(CSR_PORT_OPEN, 16'd1);
      add_reply(ACT_BYTE, 8'h00, 8'h00, 1'b1, 13'd0, PH_BUSY, 13'd1);
      add_reply(ACT_BYTE, 8'hFF, 8'hFF, 1'b1, 13'd1, PH_DONE, 13'd2);
      add_reply(ACT_BYTE, 8'h55, 8'h55, 1'b0, 13'd0, PH_DONE, 13'd2);
      add_reply(ACT_UNUSED, 8'hAA, 8'h00, 1'b0, 13'd0, PH_DONE, 13'd2);
      add_reply(ACT_RESTART, 8'hFF, 8'h00, 1'b0, 13'd0, PH_BUSY, 13'd0);
      // A zero limit times out on the first tick.
      add_cfg(CSR_TIMEOUT_LIMIT, 16'd0);
      add_reply(ACT_TICK, 8'h00, 8'h00, 1'b0, 13'd0, PH_TIMEOUT, 13'd0);
      add_reply(ACT_BYTE, 8'h12, 8'h12, 1'b0, 13'd0, PH_TIMEOUT, 13'd0);
      add_reply(ACT_RESTART, 8'h00, 8'h00, 1'b0, 13'd0, PH_BUSY, 13'd0);
      add_cfg(CSR_TIMEOUT_LIMIT, 16'd1);
      add_cfg(CSR_FRAME_MODE, {14'd0, MODE_GENERIC});
      add_reply(ACT_BYTE, 8'h41, 8'h41, 1'b0, 13'd0, PH_BUSY, 13'd0);
      add_reply(ACT_BYTE, CHAR_LT, CHAR_LT, 1'b1, 13'd0, PH_BUSY, 13'd1);
      add_req(ACT_TICK, 8'h00);
      add_req(ACT_TICK, 8'h00);
      add_req(ACT_RESTART, 8'h00);
      // Binary: a bad header, then a frame with zero length.
      add_cfg(CSR_TIMEOUT_LIMIT, 16'hFFFF);
      add_cfg(CSR_FRAME_MODE, {14'd0, MODE_BINARY});
      add_reply(ACT_BYTE, CHAR_LT, CHAR_LT, 1'b1, 13'd0, PH_BUSY, 13'd1);
      add_reply(ACT_BYTE, 8'h00, 8'h00, 1'b0, 13'd0, PH_BUSY, 13'd0);
      add_req(ACT_BYTE, CHAR_LT);
      add_req(ACT_BYTE, HEADER_BYTE);
      add_req(ACT_BYTE, 8'h80);
      add_req(ACT_BYTE, 8'h7F);
      add_req(ACT_BYTE, CHAR_GT);
      add_req(ACT_BYTE, 8'h01);
      add_req(ACT_BYTE, 8'hFE);
      add_req(ACT_BYTE, 8'h00);
      add_req(ACT_BYTE, 8'hF0);
      add_req(ACT_BYTE, 8'h5A);
      add_req(ACT_BYTE, CHAR_GT);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            settle();
            write_csr(plan[i].code, plan[i].value);
         end else begin
            send_request(plan[i].code, plan[i].value[7:0], plan[i].pinned, plan[i].want);
         end
      end

      phase_no = 0;
      while (random_sent < RANDOM_ITEMS) begin
         settle();
         no_gaps = ($urandom_range(0, 99) < 20);
         r = $urandom_range(0, 99);
         if (r < 35) mode = MODE_BINARY;
         else if (r < 55) mode = MODE_BASIC;
         else if (r < 90) mode = MODE_GENERIC;
         else mode = MODE_SPARE;
         r = $urandom_range(0, 99);
         if (phase_no == 0 || (phase_no > 1 && r >= 20 && r < 35)) limit = 16'hFFFF;
         else if (phase_no == 1 || r < 20) limit = 16'd0;
         else if (r < 75) limit = 16'($urandom_range(1, 20));
         else limit = 16'($urandom_range(0, 65535));
         open = (phase_no < 2) || ($urandom_range(0, 99) < 90);
         filler = 14'($urandom_range(0, 16383));
         write_csr(CSR_FRAME_MODE, {filler, mode});
         write_csr(CSR_PORT_OPEN, {filler, 1'b0, open});
         write_csr(CSR_TIMEOUT_LIMIT, limit);
         send(ACT_RESTART, 8'($urandom_range(0, 255)));
         phase_end = random_sent + $urandom_range(30, 70);
         while (random_sent < phase_end) run_frame();
         phase_no++;
      end

      settle();
      if (failures == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
